@@ rtl/matrix4_inverse_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the 4x4 matrix inverse core
// Shared helpers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MATRIX4_INVERSE_CORE_DEFINES_SVH
`define MATRIX4_INVERSE_CORE_DEFINES_SVH

// Property checked only outside reset.
`define M4I_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every edge, reset included.
`define M4I_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/m4i_pkg.sv @@
// ----------------------------------------------------------------------------
// m4i_pkg
// Shared types, constants and index tables of the 4x4 matrix inverse core.
// ----------------------------------------------------------------------------
package m4i_pkg;

  localparam int ELEMENT_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF     = 16;
  localparam int THR_WIDTH         = 32;
  localparam int PADDR_WIDTH       = 3;
  localparam int PDATA_WIDTH       = 32;

  localparam logic [THR_WIDTH-1:0] THRESHOLD_RESET = 32'd1;
  localparam logic                 REG_DET_THRESHOLD = 1'b0;

  localparam logic [3:0] SUB_LAST  = 4'd11;
  localparam logic [3:0] ELEM_LAST = 4'd15;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_ISSUE,
    ST_WAIT,
    ST_ABS,
    ST_CHECK,
    ST_SING,
    ST_DIV_LOAD,
    ST_DIV_GO,
    ST_DIV_WAIT
  } state_t;

  typedef enum logic [1:0] {
    PH_SUB,
    PH_COF,
    PH_DET
  } phase_t;

  typedef enum logic [1:0] {
    SRC_ELEM,
    SRC_SUB,
    SRC_COF
  } src_t;

  typedef struct packed {
    logic start;
    logic clear;
    logic neg;
  } mac_cmd_t;

  typedef struct packed {
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] c;
    logic [3:0] d;
  } sub_entry_t;

  typedef struct packed {
    logic       neg;
    logic [3:0] e0;
    logic [3:0] e1;
    logic [3:0] e2;
    logic [3:0] u0;
    logic [3:0] u1;
    logic [3:0] u2;
  } cof_entry_t;

  // 2x2 sub-determinant a*b - c*d; entries 0..5 from rows 0-1, 6..11 from rows 2-3.
  function automatic sub_entry_t sub_tab(input logic [3:0] j);
    sub_entry_t r;
    unique case (j)
      4'd0:    r = '{4'd0,  4'd5,  4'd1,  4'd4};
      4'd1:    r = '{4'd0,  4'd6,  4'd2,  4'd4};
      4'd2:    r = '{4'd0,  4'd7,  4'd3,  4'd4};
      4'd3:    r = '{4'd1,  4'd6,  4'd2,  4'd5};
      4'd4:    r = '{4'd1,  4'd7,  4'd3,  4'd5};
      4'd5:    r = '{4'd2,  4'd7,  4'd3,  4'd6};
      4'd6:    r = '{4'd8,  4'd13, 4'd9,  4'd12};
      4'd7:    r = '{4'd8,  4'd14, 4'd10, 4'd12};
      4'd8:    r = '{4'd8,  4'd15, 4'd11, 4'd12};
      4'd9:    r = '{4'd9,  4'd14, 4'd10, 4'd13};
      4'd10:   r = '{4'd9,  4'd15, 4'd11, 4'd13};
      4'd11:   r = '{4'd10, 4'd15, 4'd11, 4'd14};
      default: r = '0;
    endcase
    return r;
  endfunction

  // Adjugate entries in row-major order: e0*u0 - e1*u1 + e2*u2, negated when neg is set.
  localparam cof_entry_t COF_TAB [16] = '{
    '{1'b0, 4'd5,  4'd6,  4'd7,  4'd11, 4'd10, 4'd9},
    '{1'b1, 4'd1,  4'd2,  4'd3,  4'd11, 4'd10, 4'd9},
    '{1'b0, 4'd13, 4'd14, 4'd15, 4'd5,  4'd4,  4'd3},
    '{1'b1, 4'd9,  4'd10, 4'd11, 4'd5,  4'd4,  4'd3},
    '{1'b1, 4'd4,  4'd6,  4'd7,  4'd11, 4'd8,  4'd7},
    '{1'b0, 4'd0,  4'd2,  4'd3,  4'd11, 4'd8,  4'd7},
    '{1'b1, 4'd12, 4'd14, 4'd15, 4'd5,  4'd2,  4'd1},
    '{1'b0, 4'd8,  4'd10, 4'd11, 4'd5,  4'd2,  4'd1},
    '{1'b0, 4'd4,  4'd5,  4'd7,  4'd10, 4'd8,  4'd6},
    '{1'b1, 4'd0,  4'd1,  4'd3,  4'd10, 4'd8,  4'd6},
    '{1'b0, 4'd12, 4'd13, 4'd15, 4'd4,  4'd2,  4'd0},
    '{1'b1, 4'd8,  4'd9,  4'd11, 4'd4,  4'd2,  4'd0},
    '{1'b1, 4'd4,  4'd5,  4'd6,  4'd9,  4'd7,  4'd6},
    '{1'b0, 4'd0,  4'd1,  4'd2,  4'd9,  4'd7,  4'd6},
    '{1'b1, 4'd12, 4'd13, 4'd14, 4'd3,  4'd1,  4'd0},
    '{1'b0, 4'd8,  4'd9,  4'd10, 4'd3,  4'd1,  4'd0}
  };

endpackage

@@ rtl/m4i_front.sv @@
// ----------------------------------------------------------------------------
// m4i_front
// Collects elements into a matrix and hands each full matrix to the queue.
// ----------------------------------------------------------------------------
module m4i_front #(
  parameter int ELEMENT_WIDTH = m4i_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic signed [ELEMENT_WIDTH-1:0] element,
  input  logic                           element_valid,
  output logic                           element_ready,
  output logic                           push,
  output logic [16*ELEMENT_WIDTH-1:0]    push_data,
  input  logic                           queue_full
);
  import m4i_pkg::*;

  logic signed [ELEMENT_WIDTH-1:0] store [15];
  logic [3:0]                      load_count;
  logic                            accept;

  // The sixteenth element needs room in the queue; the others never wait.
  assign element_ready = !((load_count == ELEM_LAST) && queue_full);
  assign accept        = element_valid && element_ready;
  assign push          = accept && (load_count == ELEM_LAST);

  always_comb begin
    for (int i = 0; i < 15; i++) begin
      push_data[i*ELEMENT_WIDTH +: ELEMENT_WIDTH] = store[i];
    end
    push_data[15*ELEMENT_WIDTH +: ELEMENT_WIDTH] = element;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (accept) begin
      load_count <= load_count + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (load_count != ELEM_LAST)) begin
      store[load_count] <= element;
    end
  end

endmodule

@@ rtl/m4i_fifo.sv @@
// ----------------------------------------------------------------------------
// m4i_fifo
// Two-entry queue of whole matrices between the loader and the solver.
// ----------------------------------------------------------------------------
module m4i_fifo #(
  parameter int WIDTH = 16 * m4i_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             head_valid
);
  import m4i_pkg::*;

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/m4i_mac.sv @@
// ----------------------------------------------------------------------------
// m4i_mac
// Bit-serial signed multiply-accumulate, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module m4i_mac #(
  parameter int ELEMENT_WIDTH = m4i_pkg::ELEMENT_WIDTH_DEF,
  parameter int ACC_WIDTH     = 4 * m4i_pkg::ELEMENT_WIDTH_DEF + 5
) (
  input  logic                            clk,
  input  logic                            rst,
  input  m4i_pkg::mac_cmd_t               cmd,
  input  logic signed [ELEMENT_WIDTH-1:0] a,
  input  logic signed [ACC_WIDTH-1:0]     b,
  output logic                            busy,
  output logic signed [ACC_WIDTH-1:0]     acc
);
  import m4i_pkg::*;

  localparam int CNT_W = $clog2(ELEMENT_WIDTH);

  logic [ACC_WIDTH-1:0]     mcand;
  logic [ELEMENT_WIDTH-1:0] mplier;
  logic [CNT_W-1:0]         cnt;
  logic                     neg;
  logic                     top_bit;
  logic                     do_sub;

  // The multiplier's sign bit carries negative weight.
  assign top_bit = (cnt == CNT_W'(ELEMENT_WIDTH - 1));
  assign do_sub  = neg ^ top_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.start) begin
      busy <= 1'b1;
    end else if (busy && top_bit) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      if (cmd.clear) begin
        acc <= '0;
      end
      mcand  <= b;
      mplier <= a;
      neg    <= cmd.neg;
      cnt    <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= do_sub ? acc - signed'(mcand) : acc + signed'(mcand);
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
      cnt    <= cnt + 1'b1;
    end
  end

endmodule

@@ rtl/m4i_div.sv @@
// ----------------------------------------------------------------------------
// m4i_div
// Restoring divider with round-half-away and saturation to the element range.
// ----------------------------------------------------------------------------
module m4i_div #(
  parameter int ELEMENT_WIDTH = m4i_pkg::ELEMENT_WIDTH_DEF,
  parameter int NUM_WIDTH     = 3 * m4i_pkg::ELEMENT_WIDTH_DEF + 3 + 2 * m4i_pkg::FRAC_BITS_DEF,
  parameter int DEN_WIDTH     = 4 * m4i_pkg::ELEMENT_WIDTH_DEF + 5
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [NUM_WIDTH-1:0]            num,
  input  logic [DEN_WIDTH-1:0]            den,
  input  logic                            neg,
  output logic                            busy,
  output logic signed [ELEMENT_WIDTH-1:0] quo
);
  import m4i_pkg::*;

  localparam int EW    = ELEMENT_WIDTH;
  localparam int W     = ((NUM_WIDTH > DEN_WIDTH + EW) ? NUM_WIDTH : DEN_WIDTH + EW) + 1;
  localparam int CNT_W = $clog2(EW + 2);
  localparam logic [EW:0] LIM = (EW + 1)'(1) << (EW - 1);

  logic [W-1:0]     rem;
  logic [W-1:0]     dsh;
  logic [W-1:0]     den_w;
  logic [EW-1:0]    q;
  logic [EW:0]      qr;
  logic [EW:0]      mag;
  logic [EW:0]      neg_mag;
  logic [CNT_W-1:0] cnt;
  logic             ovf;
  logic             sgn;
  logic             ge;

  assign den_w = W'(den);
  assign ge    = (rem >= dsh);

  always_comb begin
    if (sgn) begin
      mag = (ovf || (qr > LIM)) ? LIM : qr;
    end else begin
      mag = (ovf || (qr > LIM - 1'b1)) ? LIM - 1'b1 : qr;
    end
    neg_mag = '0 - mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && (cnt == CNT_W'(EW + 1))) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // A quotient of 2^EW or more saturates whatever the rounding does.
      ovf <= (W'(num) >= (den_w << EW));
      rem <= W'(num);
      dsh <= den_w << (EW - 1);
      q   <= '0;
      sgn <= neg;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt < CNT_W'(EW)) begin
        if (ge) begin
          rem <= rem - dsh;
        end
        q   <= {q[EW-2:0], ge};
        dsh <= dsh >> 1;
      end else if (cnt == CNT_W'(EW)) begin
        qr <= {1'b0, q} + (EW + 1)'((rem << 1) >= den_w);
      end else begin
        quo <= sgn ? neg_mag[EW-1:0] : mag[EW-1:0];
      end
    end
  end

endmodule

@@ rtl/m4i_back.sv @@
// ----------------------------------------------------------------------------
// m4i_back
// Solver: sub-determinants, cofactors, determinant, singular test, quotients.
// ----------------------------------------------------------------------------
module m4i_back #(
  parameter int ELEMENT_WIDTH = m4i_pkg::ELEMENT_WIDTH_DEF,
  parameter int FRAC_BITS     = m4i_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [16*ELEMENT_WIDTH-1:0]      head,
  input  logic                             head_valid,
  output logic                             pop,
  input  logic [m4i_pkg::THR_WIDTH-1:0]    det_threshold,
  output logic signed [ELEMENT_WIDTH-1:0]  value,
  output logic                             singular,
  output logic                             last,
  output logic                             result_valid,
  input  logic                             result_ready
);
  import m4i_pkg::*;

  localparam int EW = ELEMENT_WIDTH;
  localparam int SW = 2 * EW + 1;
  localparam int CW = 3 * EW + 3;
  localparam int DW = 4 * EW + 5;
  localparam int NW = CW + 2 * FRAC_BITS;
  localparam int TW = THR_WIDTH + 3 * FRAC_BITS;
  localparam int LW = (DW > TW) ? DW : TW;

  logic signed [EW-1:0] mat   [16];
  logic signed [SW-1:0] sub_r [12];
  logic signed [CW-1:0] cof_r [16];
  logic signed [DW-1:0] det;
  logic signed [DW-1:0] b_op;
  logic [DW-1:0]        det_mag;
  logic                 det_neg;
  logic [CW-1:0]        num_mag;
  logic                 q_neg;

  state_t     state;
  state_t     state_next;
  phase_t     phase;
  logic [3:0] idx;
  logic [1:0] term;

  sub_entry_t           se;
  cof_entry_t           ce;
  logic [3:0]           a_addr;
  logic [3:0]           b_addr;
  logic [3:0]           elem_addr;
  logic [3:0]           cof_addr;
  src_t                 b_src;
  logic                 op_sub;
  logic                 op_last;
  logic signed [EW-1:0] elem_val;
  logic signed [CW-1:0] cof_val;

  mac_cmd_t             mac_cmd;
  logic                 mac_busy;
  logic signed [DW-1:0] mac_acc;
  logic                 div_start;
  logic                 div_busy;
  logic signed [EW-1:0] div_quo;

  logic step_done;
  logic out_load;
  logic out_sing;
  logic out_last;
  logic out_free;
  logic sing_hit;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      mat[i] = signed'(head[i*EW +: EW]);
    end
  end

  // Operand decode for the current multiply-accumulate term.
  always_comb begin
    se = sub_tab(idx);
    ce = COF_TAB[idx];
    a_addr  = '0;
    b_addr  = '0;
    b_src   = SRC_ELEM;
    op_sub  = 1'b0;
    op_last = 1'b0;
    unique case (phase)
      PH_SUB: begin
        a_addr  = term[0] ? se.c : se.a;
        b_addr  = term[0] ? se.d : se.b;
        b_src   = SRC_ELEM;
        op_sub  = term[0];
        op_last = term[0];
      end
      PH_COF: begin
        b_src   = SRC_SUB;
        op_last = (term == 2'd2);
        unique case (term)
          2'd0: begin
            a_addr = ce.e0;
            b_addr = ce.u0;
            op_sub = ce.neg;
          end
          2'd1: begin
            a_addr = ce.e1;
            b_addr = ce.u1;
            op_sub = !ce.neg;
          end
          default: begin
            a_addr = ce.e2;
            b_addr = ce.u2;
            op_sub = ce.neg;
          end
        endcase
      end
      PH_DET: begin
        a_addr  = {2'b00, term};
        b_addr  = {term, 2'b00};
        b_src   = SRC_COF;
        op_last = (term == 2'd3);
      end
      default: begin
        a_addr = '0;
      end
    endcase
  end

  assign elem_addr = (state == ST_FETCH) ? b_addr : a_addr;
  assign elem_val  = mat[elem_addr];
  assign cof_addr  = (state == ST_DIV_LOAD) ? idx : b_addr;
  assign cof_val   = cof_r[cof_addr];
  assign out_free  = !result_valid || result_ready;
  assign sing_hit  = (det_mag == '0) ||
                     (LW'(det_mag) < (LW'(det_threshold) << (3 * FRAC_BITS)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    mac_cmd.start = 1'b0;
    mac_cmd.clear = (term == 2'd0);
    mac_cmd.neg   = op_sub;
    div_start     = 1'b0;
    pop           = 1'b0;
    step_done     = 1'b0;
    out_load      = 1'b0;
    out_sing      = 1'b0;
    out_last      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (head_valid) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        mac_cmd.start = 1'b1;
        state_next    = ST_WAIT;
      end
      ST_WAIT: begin
        if (!mac_busy) begin
          step_done  = 1'b1;
          state_next = (op_last && (phase == PH_DET)) ? ST_ABS : ST_FETCH;
        end
      end
      ST_ABS: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = sing_hit ? ST_SING : ST_DIV_LOAD;
      end
      ST_SING: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_sing   = 1'b1;
          out_last   = 1'b1;
          pop        = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DIV_LOAD: begin
        state_next = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!div_busy && out_free) begin
          out_load = 1'b1;
          out_last = (idx == ELEM_LAST);
          if (idx == ELEM_LAST) begin
            pop        = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_DIV_LOAD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequence counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SUB;
      idx   <= '0;
      term  <= '0;
    end else if (state == ST_IDLE) begin
      phase <= PH_SUB;
      idx   <= '0;
      term  <= '0;
    end else if (step_done) begin
      if (op_last) begin
        term <= '0;
        unique case (phase)
          PH_SUB: begin
            if (idx == SUB_LAST) begin
              phase <= PH_COF;
              idx   <= '0;
            end else begin
              idx <= idx + 4'd1;
            end
          end
          PH_COF: begin
            if (idx == ELEM_LAST) begin
              phase <= PH_DET;
            end
            idx <= idx + 4'd1;
          end
          default: begin
            idx <= '0;
          end
        endcase
      end else begin
        term <= term + 2'd1;
      end
    end else if (state == ST_CHECK) begin
      idx <= '0;
    end else if (out_load && (state == ST_DIV_WAIT)) begin
      idx <= idx + 4'd1;
    end
  end

  // Working values.
  always_ff @(posedge clk) begin
    if (state == ST_FETCH) begin
      unique case (b_src)
        SRC_ELEM: b_op <= DW'(elem_val);
        SRC_SUB:  b_op <= DW'(sub_r[b_addr]);
        SRC_COF:  b_op <= DW'(cof_val);
        default:  b_op <= '0;
      endcase
    end
    if (step_done && op_last) begin
      unique case (phase)
        PH_SUB:  sub_r[idx] <= mac_acc[SW-1:0];
        PH_COF:  cof_r[idx] <= mac_acc[CW-1:0];
        default: det        <= mac_acc;
      endcase
    end
    if (state == ST_ABS) begin
      det_neg <= det[DW-1];
      det_mag <= det[DW-1] ? DW'(-det) : DW'(det);
    end
    if (state == ST_DIV_LOAD) begin
      num_mag <= cof_val[CW-1] ? CW'(-cof_val) : CW'(cof_val);
      q_neg   <= cof_val[CW-1] ^ det_neg;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      value    <= out_sing ? '0 : div_quo;
      singular <= out_sing;
      last     <= out_last;
    end
  end

  m4i_mac #(
    .ELEMENT_WIDTH (EW),
    .ACC_WIDTH     (DW)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mac_cmd),
    .a    (elem_val),
    .b    (b_op),
    .busy (mac_busy),
    .acc  (mac_acc)
  );

  m4i_div #(
    .ELEMENT_WIDTH (EW),
    .NUM_WIDTH     (NW),
    .DEN_WIDTH     (DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (NW'(num_mag) << (2 * FRAC_BITS)),
    .den   (det_mag),
    .neg   (q_neg),
    .busy  (div_busy),
    .quo   (div_quo)
  );

endmodule

@@ rtl/matrix4_inverse_core.sv @@
// ----------------------------------------------------------------------------
// matrix4_inverse_core
// Exact fixed-point inverse of a 4x4 matrix by cofactors, with singular test.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                                   Direction
//   element   element_valid, element_ready, element     request in
//   result    result_valid, result_ready, value,        request out
//             singular, last
//   config    psel, penable, pwrite, paddr, pwdata,     APB write/read
//             prdata, pready
//
// Elements load one per cycle into the front store; the sixteenth is accepted
// as long as the matrix queue (two entries) has room.
// The solver runs every product through one bit-serial multiply-accumulate
// unit (with steps for operand fetch, issue and completion around each
// product) and every quotient through one restoring divider (with steps
// for operand load and start).
// Reset is synchronous and clears all control state; no clearing pass runs.
// A stalled result holds in the output register while the front keeps
// loading the next matrix.
//
module matrix4_inverse_core #(
  parameter int ELEMENT_WIDTH = m4i_pkg::ELEMENT_WIDTH_DEF,
  parameter int FRAC_BITS     = m4i_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [ELEMENT_WIDTH-1:0]    element,
  input  logic                               element_valid,
  output logic                               element_ready,
  output logic signed [ELEMENT_WIDTH-1:0]    value,
  output logic                               singular,
  output logic                               last,
  output logic                               result_valid,
  input  logic                               result_ready,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [m4i_pkg::PADDR_WIDTH-1:0]    paddr,
  input  logic [m4i_pkg::PDATA_WIDTH-1:0]    pwdata,
  output logic [m4i_pkg::PDATA_WIDTH-1:0]    prdata,
  output logic                               pready
);
  import m4i_pkg::*;

  localparam int MW = 16 * ELEMENT_WIDTH;

  logic [THR_WIDTH-1:0] det_threshold;
  logic                 push;
  logic [MW-1:0]        push_data;
  logic                 queue_full;
  logic                 pop;
  logic [MW-1:0]        head;
  logic                 head_valid;

  // The register index is the word address; bits below it pick bytes and
  // are ignored. Writes to any other index are dropped.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DET_THRESHOLD) ? PDATA_WIDTH'(det_threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DET_THRESHOLD)) begin
      det_threshold <= pwdata[THR_WIDTH-1:0];
    end
  end

  // Front: gathers sixteen elements into one matrix request for the queue.
  m4i_front #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .element       (element),
    .element_valid (element_valid),
    .element_ready (element_ready),
    .push          (push),
    .push_data     (push_data),
    .queue_full    (queue_full)
  );

  // The queue lets the front keep loading while the solver is busy.
  m4i_fifo #(
    .WIDTH (MW)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (queue_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // Back: solves the matrix at the queue head and releases it as the
  // final result is loaded into the output register.
  m4i_back #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .FRAC_BITS     (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .head_valid    (head_valid),
    .pop           (pop),
    .det_threshold (det_threshold),
    .value         (value),
    .singular      (singular),
    .last          (last),
    .result_valid  (result_valid),
    .result_ready  (result_ready)
  );

endmodule

@@ rtl/m4i_checker.sv @@
// ----------------------------------------------------------------------------
// m4i_checker
// Port-level checks of the 4x4 matrix inverse core, bound to the top level.
// ----------------------------------------------------------------------------
`include "matrix4_inverse_core_defines.svh"

module m4i_checker #(
  parameter int ELEMENT_WIDTH = m4i_pkg::ELEMENT_WIDTH_DEF
) (
  input logic                     clk,
  input logic                     rst,
  input logic [ELEMENT_WIDTH-1:0] value,
  input logic                     singular,
  input logic                     last,
  input logic                     result_valid,
  input logic                     result_ready
);
  import m4i_pkg::*;

  `M4I_ASSERT_RUN(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(value) && $stable(singular) && $stable(last), "result changed while stalled")
  `M4I_ASSERT_RUN(a_singular_alone, result_valid && singular |-> last && (value == '0), "singular result must be a lone zero")
  `M4I_ASSERT_ALL(a_reset_quiet, rst |=> !result_valid, "result valid right after reset")

endmodule

bind matrix4_inverse_core m4i_checker #(
  .ELEMENT_WIDTH (ELEMENT_WIDTH)
) u_m4i_checker (
  .clk          (clk),
  .rst          (rst),
  .value        (value),
  .singular     (singular),
  .last         (last),
  .result_valid (result_valid),
  .result_ready (result_ready)
);

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of matrix4_inverse_core
// Streams whole 4x4 Q16.16 matrices into the core and checks every result
// request against an exact wide-integer cofactor inverse computed here, with
// random idling on both channels and threshold changes between phases.
// ----------------------------------------------------------------------------
module tb;
  import m4i_pkg::*;

  // Exact arithmetic is done on 256-bit signed integers, wide enough for
  // the determinant (about 130 bits) and the shifted cofactors.
  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [31:0] value;
    logic               singular;
    logic               last;
  } inv_result_t;

  localparam logic [PADDR_WIDTH-1:0] THR_ADDR = PADDR_WIDTH'(0);
  localparam int DRAIN_CYCLES = 4000;  // a bit above one solver pass
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic signed [31:0] element = '0;
  logic element_valid = 1'b0;
  logic element_ready;
  logic signed [31:0] value;
  logic singular, last, result_valid;
  logic result_ready = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_WIDTH-1:0] paddr = '0;
  logic [PDATA_WIDTH-1:0] pwdata = '0;
  logic [PDATA_WIDTH-1:0] prdata;
  logic pready;

  matrix4_inverse_core u_top (
    .clk, .rst, .element, .element_valid, .element_ready,
    .value, .singular, .last, .result_valid, .result_ready,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #10 clk = ~clk;

  // Predictor state: our own copy of the element store, load counter and
  // threshold register.
  logic signed [31:0] mat_store [16];
  logic [3:0]         load_idx = '0;
  logic [31:0]        thr_shadow = THRESHOLD_RESET;
  inv_result_t        inverse_q [$];

  int errors = 0, mismatches = 0;
  int matrices_sent = 0, regular_seen = 0, singular_seen = 0, results_seen = 0;
  bit idle_on = 1'b1;

  // Adjugate recipe per output element: sign, three element indices and three
  // sub-determinant indices (0..5 from rows 0-1, 6..11 from rows 2-3).
  int cof_recipe [16][7] = '{
    '{0, 5, 6, 7, 11, 10, 9}, '{1, 1, 2, 3, 11, 10, 9},
    '{0, 13, 14, 15, 5, 4, 3}, '{1, 9, 10, 11, 5, 4, 3},
    '{1, 4, 6, 7, 11, 8, 7}, '{0, 0, 2, 3, 11, 8, 7},
    '{1, 12, 14, 15, 5, 2, 1}, '{0, 8, 10, 11, 5, 2, 1},
    '{0, 4, 5, 7, 10, 8, 6}, '{1, 0, 1, 3, 10, 8, 6},
    '{0, 12, 13, 15, 4, 2, 0}, '{1, 8, 9, 11, 4, 2, 0},
    '{1, 4, 5, 6, 9, 7, 6}, '{0, 0, 1, 2, 9, 7, 6},
    '{1, 12, 13, 14, 3, 1, 0}, '{0, 8, 9, 10, 3, 1, 0}
  };

  function automatic wide_t minor2(int a, int b, int c, int d);
    wide_t ea, eb, ec, ed;
    ea = mat_store[a]; eb = mat_store[b]; ec = mat_store[c]; ed = mat_store[d];
    return ea * eb - ec * ed;
  endfunction

  // Rounded (ties away from zero) and saturated quotient of num / det.
  function automatic logic signed [31:0] round_div(wide_t num, wide_t det);
    wide_t an, ad, q, r;
    logic neg;
    neg = (num < 0) != (det < 0);
    an = (num < 0) ? -num : num;
    ad = (det < 0) ? -det : det;
    q = an / ad;
    r = an % ad;
    if (2 * r >= ad) q = q + 1;
    if (neg) begin
      if (q > wide_t'(64'h8000_0000)) q = wide_t'(64'h8000_0000);
      return -q[31:0];
    end
    if (q > wide_t'(64'h7FFF_FFFF)) q = wide_t'(64'h7FFF_FFFF);
    return q[31:0];
  endfunction

  // Loads one element; on the sixteenth the whole inverse is predicted.
  task automatic predict_inverse(input logic signed [31:0] el);
    wide_t sd [12];
    wide_t det, lim, cof, ea, eb, ec;
    inv_result_t r;
    mat_store[load_idx] = el;
    load_idx = load_idx + 4'd1;
    if (load_idx != 4'd0) return;
    matrices_sent++;
    sd[0] = minor2(0, 5, 1, 4);    sd[1] = minor2(0, 6, 2, 4);
    sd[2] = minor2(0, 7, 3, 4);    sd[3] = minor2(1, 6, 2, 5);
    sd[4] = minor2(1, 7, 3, 5);    sd[5] = minor2(2, 7, 3, 6);
    sd[6] = minor2(8, 13, 9, 12);  sd[7] = minor2(8, 14, 10, 12);
    sd[8] = minor2(8, 15, 11, 12); sd[9] = minor2(9, 14, 10, 13);
    sd[10] = minor2(9, 15, 11, 13); sd[11] = minor2(10, 15, 11, 14);
    det = sd[0] * sd[11] - sd[1] * sd[10] + sd[2] * sd[9]
        + sd[3] * sd[8] - sd[4] * sd[7] + sd[5] * sd[6];
    lim = wide_t'({224'b0, thr_shadow}) <<< 48;
    if (det == 0 || ((det < 0) ? -det : det) < lim) begin
      r.value = '0; r.singular = 1'b1; r.last = 1'b1;
      inverse_q.push_back(r);
      return;
    end
    for (int k = 0; k < 16; k++) begin
      ea = mat_store[cof_recipe[k][1]];
      eb = mat_store[cof_recipe[k][2]];
      ec = mat_store[cof_recipe[k][3]];
      cof = ea * sd[cof_recipe[k][4]] - eb * sd[cof_recipe[k][5]]
          + ec * sd[cof_recipe[k][6]];
      if (cof_recipe[k][0] != 0) cof = -cof;
      r.value = round_div(cof <<< 32, det);
      r.singular = 1'b0;
      r.last = (k == 15);
      inverse_q.push_back(r);
    end
  endtask

  // Sends one element request. A random gap may precede it; valid is then
  // dropped and raised again on different falling edges.
  task automatic send_element(input logic signed [31:0] el);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      element_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    element <= el;
    element_valid <= 1'b1;
    @(posedge clk);
    while (!element_ready) @(posedge clk);
    predict_inverse(el);
  endtask

  task automatic send_matrix(input logic signed [31:0] m [16]);
    for (int i = 0; i < 16; i++) send_element(m[i]);
  endtask

  // Waits until every predicted result has been taken, then lets the solver
  // settle so a register write cannot land mid-computation.
  task automatic drain_results();
    @(negedge clk);
    element_valid <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write with setup and access phases, followed by a read-back check.
  task automatic write_threshold(input logic [31:0] thr);
    @(negedge clk);
    element_valid <= 1'b0;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= THR_ADDR; pwdata <= thr;
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    thr_shadow = thr;
    @(negedge clk);
    penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== thr) begin
      errors++;
      $display("threshold read-back: expected %h, got %h", thr, prdata);
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  function automatic void fill_diag(output logic signed [31:0] m [16],
                                    input logic signed [31:0] d0, d1, d2, d3);
    foreach (m[i]) m[i] = '0;
    m[0] = d0; m[5] = d1; m[10] = d2; m[15] = d3;
  endfunction

  // Random matrix of one of several shapes: well-conditioned near-diagonal
  // (meaningful inverse values), full-range noise, a repeated row (exactly
  // singular) and tiny elements (below threshold).
  task automatic random_matrix(output logic signed [31:0] m [16]);
    int kind, src, dst;
    kind = $urandom_range(0, 9);
    foreach (m[i]) begin
      case (kind)
        0, 1:    m[i] = $urandom;
        7:       m[i] = $signed($urandom_range(0, 15)) - 8;
        default: m[i] = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
      endcase
    end
    if (kind >= 2 && kind <= 6) begin
      for (int i = 0; i < 4; i++)
        m[5 * i] = ($urandom_range(0, 1) ? 1 : -1) *
                   $signed($urandom_range(32'h0000_4000, 32'h0008_0000));
    end
    if (kind == 8 || kind == 9) begin
      src = $urandom_range(0, 3);
      dst = (src + $urandom_range(1, 3)) % 4;
      for (int j = 0; j < 4; j++) m[4 * dst + j] = m[4 * src + j];
    end
  endtask

  // Result checker: every accepted result is compared with the oldest
  // prediction.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (inverse_q.size() == 0) begin
        errors++;
        $display("unexpected result: value %h singular %b last %b",
                 value, singular, last);
      end else begin
        inv_result_t e;
        e = inverse_q.pop_front();
        if (e.singular) singular_seen++;
        else if (e.last) regular_seen++;
        if (value !== e.value || singular !== e.singular || last !== e.last) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h/%b/%b, got %h/%b/%b",
                     e.value, e.singular, e.last, value, singular, last);
        end
      end
    end
  end

  // Result back-pressure: random stall bursts while idling is on, always
  // ready otherwise.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 17);
        result_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      result_ready <= 1'b1;
    end
  end

  task automatic test_directed();
    logic signed [31:0] m [16];
    // Identity gives an identity inverse.
    fill_diag(m, ONE, ONE, ONE, ONE);
    send_matrix(m);
    // Determinant exactly at the threshold bound is regular; the tiny
    // corner pivot forces positive and negative saturation.
    fill_diag(m, 32'sd1, ONE, ONE, ONE);
    send_matrix(m);
    fill_diag(m, -32'sd1, ONE, ONE, ONE);
    send_matrix(m);
    // Field extremes mixed across the whole matrix.
    foreach (m[i]) m[i] = (i % 3 == 0) ? 32'sh8000_0000 :
                          (i % 3 == 1) ? 32'sh7FFF_FFFF : -32'sd1;
    m[0] = 32'sh7FFF_FFFF;
    send_matrix(m);
    // All zeros is singular.
    foreach (m[i]) m[i] = '0;
    send_matrix(m);
  endtask

  task automatic test_threshold();
    logic signed [31:0] m [16];
    drain_results();
    write_threshold(32'hFFFF_FFFF);
    fill_diag(m, ONE, ONE, ONE, ONE);   // now judged singular
    send_matrix(m);
    foreach (m[i]) m[i] = $urandom;      // huge determinant still passes
    send_matrix(m);
    drain_results();
    write_threshold(32'h0001_0000);
    fill_diag(m, 32'sh0000_8000, ONE, ONE, ONE);  // just below the bound
    send_matrix(m);
    fill_diag(m, ONE, ONE, ONE, -ONE);            // exactly at the bound
    send_matrix(m);
    drain_results();
    write_threshold(THRESHOLD_RESET);
  endtask

  task automatic test_random(input int count);
    logic signed [31:0] m [16];
    repeat (count) begin
      random_matrix(m);
      send_matrix(m);
    end
  endtask

  // The sender holds off until every predicted result has come back.
  task automatic test_pressure();
    logic signed [31:0] m [16];
    @(negedge clk);
    element_valid <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk);
    random_matrix(m);
    send_matrix(m);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_directed();
    test_threshold();
    test_random(5);
    test_pressure();
    idle_on = 1'b0;
    test_random(2);
    @(negedge clk) element_valid <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d matrices: %0d regular, %0d singular, %0d results checked.",
             matrices_sent, regular_seen, singular_seen, results_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures, %0d field mismatches", errors, mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", inverse_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
